### sv/ffpa_pkg.sv
// Shared page count, command codes and status codes for the first-fit page allocator.
package ffpa_pkg;

	localparam int PAGE_COUNT = 1024;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_STATE = 2'd3;

endpackage

### sv/first_fit_page_allocator.sv
// First-fit page allocator with coalescing of freed runs, built around one page table memory.
//
// Usage: a command transaction is taken on the rising edge where start is high and busy
// is low; command, page_index and page_count are sampled there. Exactly one result
// follows, shown on status, block_start and free_count while done is high for one cycle.
// The receiver cannot hold results off, and busy is already low while done is high, so a
// new command may be issued in that cycle.
// A rejected command (zero count, unknown code, run past the end, request above the free
// total) is answered in the cycle after it is taken. Add region checks that every page of
// the run is reserved and then releases it, or answers with a state error after the check
// when a page is already free. Free does the same, then reads the entry above and walks
// down through the free run below one entry per cycle. Allocate scans the table from page
// zero one entry per cycle and then marks the taken pages. The page table has a single
// read port, and every step makes at most one table access.
// After reset the block holds busy high while it writes every table entry to reserved
// with length zero; the free total starts at zero.
module first_fit_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [9:0]  page_index,
	input  logic [10:0] page_count,
	output logic        done,
	output logic [1:0]  status,
	output logic [9:0]  block_start,
	output logic [10:0] free_count
);

	localparam int AW = $clog2(ffpa_pkg::PAGE_COUNT);
	localparam int LW = AW + 1;
	localparam int EW = LW + 1;
	localparam int RW = ((LW > 11) ? LW : 11) + 1;

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CHK     = 4'd2;
	localparam logic [3:0] S_REL     = 4'd3;
	localparam logic [3:0] S_MA_RD   = 4'd4;
	localparam logic [3:0] S_MA_EV   = 4'd5;
	localparam logic [3:0] S_MA_HD   = 4'd6;
	localparam logic [3:0] S_MB_RD   = 4'd7;
	localparam logic [3:0] S_MB_SCAN = 4'd8;
	localparam logic [3:0] S_MB_WR1  = 4'd9;
	localparam logic [3:0] S_MB_WR2  = 4'd10;
	localparam logic [3:0] S_AL_SCAN = 4'd11;
	localparam logic [3:0] S_AL_WR   = 4'd12;
	localparam logic [3:0] S_AL_REM  = 4'd13;

	localparam logic [LW-1:0] PC_L = LW'(ffpa_pkg::PAGE_COUNT);

	logic [EW-1:0] mem [ffpa_pkg::PAGE_COUNT];
	logic [EW-1:0] rd_q;
	logic          rdv_q;
	logic [AW-1:0] rda_q;

	logic          rd_en, we;
	logic [AW-1:0] raddr, waddr;
	logic [EW-1:0] wdata;

	logic [3:0]    state_q;
	logic [1:0]    cmd_q;
	logic [AW-1:0] idx_q;
	logic [LW-1:0] cnt_q, end_q, ptr_q, free_q, headlen_q, hitlen_q, jlen_q;
	logic [AW-1:0] jaddr_q;
	logic          bad_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [AW-1:0] start_q;

	logic          rd_used;
	logic [LW-1:0] rd_len;
	logic [RW-1:0] run_end;

	assign rd_used = rd_q[EW-1];
	assign rd_len  = rd_q[LW-1:0];
	assign run_end = RW'(page_index) + RW'(page_count);

	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = {1'b1, {LW{1'b0}}};
			end
			S_CHK: begin
				if (ptr_q != end_q) begin
					rd_en = 1'b1;
					raddr = ptr_q[AW-1:0];
				end
			end
			S_REL: begin
				we    = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = {1'b0, (ptr_q == LW'(idx_q)) ? cnt_q : {LW{1'b0}}};
			end
			S_MA_RD: begin
				if (end_q < PC_L) begin
					rd_en = 1'b1;
					raddr = end_q[AW-1:0];
				end
			end
			S_MA_EV: begin
				if (!rd_used && rd_len != '0) begin
					we    = 1'b1;
					waddr = end_q[AW-1:0];
				end
			end
			S_MA_HD: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = {1'b0, headlen_q};
			end
			S_MB_RD: begin
				if (idx_q != '0) begin
					rd_en = 1'b1;
					raddr = idx_q - 1'b1;
				end
			end
			S_MB_SCAN: begin
				if (rda_q != '0) begin
					rd_en = 1'b1;
					raddr = rda_q - 1'b1;
				end
			end
			S_MB_WR1: begin
				we    = 1'b1;
				waddr = jaddr_q;
				wdata = {1'b0, jlen_q + headlen_q};
			end
			S_MB_WR2: begin
				we    = 1'b1;
				waddr = idx_q;
			end
			S_AL_SCAN: begin
				if (ptr_q != PC_L) begin
					rd_en = 1'b1;
					raddr = ptr_q[AW-1:0];
				end
			end
			S_AL_WR: begin
				we    = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = {1'b1, {LW{1'b0}}};
			end
			S_AL_REM: begin
				we    = 1'b1;
				waddr = end_q[AW-1:0];
				wdata = {1'b0, hitlen_q - cnt_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			ptr_q    <= '0;
			free_q   <= '0;
			done_q   <= 1'b0;
			status_q <= ffpa_pkg::ST_OK;
			start_q  <= '0;
			rdv_q    <= 1'b0;
			rda_q    <= '0;
			bad_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rdv_q  <= rd_en;
			rda_q  <= raddr;
			unique case (state_q)
				S_CLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == PC_L - 1'b1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						start_q <= '0;
						if (page_count == '0 || command == ffpa_pkg::CMD_RSVD) begin
							done_q   <= 1'b1;
							status_q <= ffpa_pkg::ST_RANGE;
						end else if (command == ffpa_pkg::CMD_ALLOC) begin
							if (RW'(page_count) > RW'(free_q)) begin
								done_q   <= 1'b1;
								status_q <= ffpa_pkg::ST_NOFIT;
							end else begin
								cnt_q   <= LW'(page_count);
								ptr_q   <= '0;
								state_q <= S_AL_SCAN;
							end
						end else if (run_end > RW'(ffpa_pkg::PAGE_COUNT)) begin
							done_q   <= 1'b1;
							status_q <= ffpa_pkg::ST_RANGE;
						end else begin
							idx_q   <= AW'(page_index);
							cnt_q   <= LW'(page_count);
							end_q   <= LW'(run_end);
							ptr_q   <= LW'(page_index);
							bad_q   <= 1'b0;
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (rdv_q && !rd_used) begin
						bad_q <= 1'b1;
					end
					if (ptr_q != end_q) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!rdv_q) begin
						if (bad_q) begin
							done_q   <= 1'b1;
							status_q <= ffpa_pkg::ST_STATE;
							state_q  <= S_IDLE;
						end else begin
							ptr_q   <= LW'(idx_q);
							state_q <= S_REL;
						end
					end
				end
				S_REL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q + 1'b1 == end_q) begin
						if (cmd_q == ffpa_pkg::CMD_ADD) begin
							done_q   <= 1'b1;
							status_q <= ffpa_pkg::ST_OK;
							free_q   <= free_q + cnt_q;
							state_q  <= S_IDLE;
						end else begin
							headlen_q <= cnt_q;
							state_q   <= S_MA_RD;
						end
					end
				end
				S_MA_RD: begin
					state_q <= (end_q < PC_L) ? S_MA_EV : S_MB_RD;
				end
				S_MA_EV: begin
					if (!rd_used && rd_len != '0) begin
						headlen_q <= headlen_q + rd_len;
						state_q   <= S_MA_HD;
					end else begin
						state_q <= S_MB_RD;
					end
				end
				S_MA_HD: begin
					state_q <= S_MB_RD;
				end
				S_MB_RD: begin
					if (idx_q == '0) begin
						done_q   <= 1'b1;
						status_q <= ffpa_pkg::ST_OK;
						free_q   <= free_q + cnt_q;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_MB_SCAN;
					end
				end
				S_MB_SCAN: begin
					if (!rd_used) begin
						jaddr_q <= rda_q;
						jlen_q  <= rd_len;
						if (rda_q != '0 && rd_len == '0) begin
							state_q <= S_MB_SCAN;
						end else if (rd_len != '0) begin
							state_q <= S_MB_WR1;
						end else begin
							done_q   <= 1'b1;
							status_q <= ffpa_pkg::ST_OK;
							free_q   <= free_q + cnt_q;
							state_q  <= S_IDLE;
						end
					end else begin
						done_q   <= 1'b1;
						status_q <= ffpa_pkg::ST_OK;
						free_q   <= free_q + cnt_q;
						state_q  <= S_IDLE;
					end
				end
				S_MB_WR1: begin
					state_q <= S_MB_WR2;
				end
				S_MB_WR2: begin
					done_q   <= 1'b1;
					status_q <= ffpa_pkg::ST_OK;
					free_q   <= free_q + cnt_q;
					state_q  <= S_IDLE;
				end
				S_AL_SCAN: begin
					if (rdv_q && !rd_used && rd_len >= cnt_q) begin
						idx_q    <= rda_q;
						hitlen_q <= rd_len;
						ptr_q    <= LW'(rda_q);
						end_q    <= LW'(rda_q) + cnt_q;
						state_q  <= S_AL_WR;
					end else if (ptr_q != PC_L) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!rdv_q) begin
						done_q   <= 1'b1;
						status_q <= ffpa_pkg::ST_NOFIT;
						state_q  <= S_IDLE;
					end
				end
				S_AL_WR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q + 1'b1 == end_q) begin
						if (hitlen_q > cnt_q) begin
							state_q <= S_AL_REM;
						end else begin
							done_q   <= 1'b1;
							status_q <= ffpa_pkg::ST_OK;
							start_q  <= idx_q;
							free_q   <= free_q - cnt_q;
							state_q  <= S_IDLE;
						end
					end
				end
				S_AL_REM: begin
					done_q   <= 1'b1;
					status_q <= ffpa_pkg::ST_OK;
					start_q  <= idx_q;
					free_q   <= free_q - cnt_q;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign block_start = start_q;
	assign free_count  = free_q;

endmodule

### sv/ffpa_checker.sv
// Port-level checker for the first-fit page allocator and its bind statement.
module ffpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  command,
	input logic [10:0] page_count,
	input logic        done,
	input logic [1:0]  status,
	input logic [9:0]  block_start
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result shown while the block is still busy.");

	a_reject_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (page_count == 11'd0 || command == ffpa_pkg::CMD_RSVD))
		|=> (done && status == ffpa_pkg::ST_RANGE))
		else $error("Zero count or unknown command not rejected in one cycle.");

	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ffpa_pkg::ST_OK) |-> (block_start == 10'd0))
		else $error("Failed transaction reports a nonzero start page.");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("Accepted transaction neither started work nor completed.");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.command     (command),
	.page_count  (page_count),
	.done        (done),
	.status      (status),
	.block_start (block_start)
);
